@@ hw/rtl/srlc_pkg.sv @@
// Shared types, constants and character helpers for the S-record line checker.
package srlc_pkg;

  localparam int LINE_CHARS = 1024;
  localparam int POS_W = $clog2(LINE_CHARS);
  localparam int LEN_W = POS_W + 1;
  localparam int FLAG_W = 6;

  localparam int FLAG_NO_S = 0;
  localparam int FLAG_BAD_TYPE = 1;
  localparam int FLAG_BAD_HEX = 2;
  localparam int FLAG_BYTE_COUNT = 3;
  localparam int FLAG_CHECKSUM = 4;
  localparam int FLAG_COUNT = 5;

  localparam logic [7:0] CH_S = 8'h53;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_A = 8'h41;
  localparam logic [7:0] CH_F = 8'h46;
  localparam logic [3:0] NIB_TEN = 4'd10;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [LEN_W-1:0] len_t;

  typedef struct packed {
    logic [7:0]  char_code;
    logic        line_end;
    logic        check_count;
    logic [15:0] expected_count;
  } beat_t;

  typedef struct packed {
    logic [FLAG_W-1:0] error_flags;
    logic [2:0]        first_error;
    logic [3:0]        record_type;
  } result_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] c);
    hex_t h;
    logic [7:0] d;
    h.ok = 1'b0;
    h.nib = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      h.ok = 1'b1;
      h.nib = d[3:0];
    end else if (c >= CH_A && c <= CH_F) begin
      d = c - CH_A;
      h.ok = 1'b1;
      h.nib = d[3:0] + NIB_TEN;
    end
    return h;
  endfunction

  function automatic logic [2:0] first_set(input logic [FLAG_W-1:0] flags);
    logic [2:0] f;
    f = 3'd0;
    for (int k = FLAG_W - 1; k >= 0; k--) begin
      if (flags[k]) begin
        f = 3'(k + 1);
      end
    end
    return f;
  endfunction

endpackage

@@ hw/rtl/srlc_line_checker.sv @@
// Top level of the S-record line checker: input register, line logic and result register.
// A result is written to the result register when the line-end beat leaves the input register.
// One character beat is accepted every cycle unless a line-end beat waits on a stalled
// result; the result register frees the input side while a finished result waits.
// A stalled result holds back only a line-end beat; other characters keep flowing.
// Synchronous reset empties both registers and clears all per-line state.
module srecord_line_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  char_code,
  input  logic        line_end,
  input  logic        check_count,
  input  logic [15:0] expected_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [5:0]  error_flags,
  output logic [2:0]  first_error,
  output logic [3:0]  record_type
);
  import srlc_pkg::*;

  beat_t   in_beat;
  beat_t   beat;
  logic    step;
  logic    out_free;
  result_t line_result;
  result_t result;

  assign in_beat.char_code = char_code;
  assign in_beat.line_end = line_end;
  assign in_beat.check_count = check_count;
  assign in_beat.expected_count = expected_count;
  assign out_free = !out_valid || !out_stall;

  srlc_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_beat  (in_beat),
    .out_free (out_free),
    .step     (step),
    .beat     (beat)
  );

  srlc_line_eval u_line_eval (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .beat   (beat),
    .result (line_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && beat.line_end) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && beat.line_end) begin
      result <= line_result;
    end
  end

  assign error_flags = result.error_flags;
  assign first_error = result.first_error;
  assign record_type = result.record_type;

endmodule

@@ hw/rtl/srlc_in_stage.sv @@
// Input register of the checker: holds one character beat until the line logic takes it.
module srlc_in_stage (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  srlc_pkg::beat_t in_beat,
  input  logic          out_free,
  output logic          step,
  output srlc_pkg::beat_t beat
);
  import srlc_pkg::*;

  logic held;
  logic load;

  assign step = held && (!beat.line_end || out_free);
  assign in_stall = held && !step;
  assign load = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (load) begin
      held <= 1'b1;
    end else if (step) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      beat <= in_beat;
    end
  end

endmodule

@@ hw/rtl/srlc_line_eval.sv @@
// Per-line state of the checker and the evaluation of the error flags at line end.
module srlc_line_eval (
  input  logic            clk,
  input  logic            rst,
  input  logic            step,
  input  srlc_pkg::beat_t beat,
  output srlc_pkg::result_t result
);
  import srlc_pkg::*;

  pos_t        char_position, char_position_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic [7:0]  byte_sum, byte_sum_next;
  logic [7:0]  last_byte, last_byte_next;
  logic [7:0]  declared_bytes, declared_bytes_next;
  logic [15:0] count_field, count_field_next;
  logic [2:0]  early_flags, early_flags_next;
  logic [3:0]  type_digit, type_digit_next;

  hex_t              hx;
  logic [7:0]        b;
  logic [7:0]        digit;
  len_t              len;
  len_t              half;
  logic [FLAG_W-1:0] flags;

  always_comb begin
    hx = hex_decode(beat.char_code);
    b = {high_nibble, hx.nib};
    digit = beat.char_code - CH_0;
    early_flags_next = early_flags;
    type_digit_next = type_digit;
    high_nibble_next = high_nibble;
    byte_sum_next = byte_sum;
    last_byte_next = last_byte;
    declared_bytes_next = declared_bytes;
    count_field_next = count_field;

    if (char_position == '0) begin
      if (beat.char_code != CH_S) begin
        early_flags_next[FLAG_NO_S] = 1'b1;
      end
    end else if (!hx.ok) begin
      early_flags_next[FLAG_BAD_HEX] = 1'b1;
    end

    if (char_position == pos_t'(1)) begin
      if (beat.char_code >= CH_0 && beat.char_code <= CH_9) begin
        type_digit_next = digit[3:0];
      end else begin
        type_digit_next = 4'd0;
        early_flags_next[FLAG_BAD_TYPE] = 1'b1;
      end
    end

    if (char_position >= pos_t'(2)) begin
      if (!char_position[0]) begin
        high_nibble_next = hx.nib;
      end else begin
        if (char_position == pos_t'(3)) begin
          declared_bytes_next = b;
        end
        byte_sum_next = byte_sum + b;
        last_byte_next = b;
      end
    end

    if (char_position >= pos_t'(4) && char_position <= pos_t'(7)) begin
      count_field_next = {count_field[11:0], hx.nib};
    end

    if (char_position == pos_t'(LINE_CHARS - 1)) begin
      char_position_next = char_position;
    end else begin
      char_position_next = char_position + pos_t'(1);
    end

    len = len_t'(char_position) + len_t'(1);
    half = (len - len_t'(4)) >> 1;
    flags = '0;
    flags[FLAG_NO_S] = early_flags_next[FLAG_NO_S];
    flags[FLAG_BAD_TYPE] = early_flags_next[FLAG_BAD_TYPE] || (len < len_t'(2));
    flags[FLAG_BAD_HEX] = early_flags_next[FLAG_BAD_HEX];
    if (len < len_t'(4) || len[0]) begin
      flags[FLAG_BYTE_COUNT] = 1'b1;
      flags[FLAG_CHECKSUM] = 1'b1;
    end else begin
      flags[FLAG_BYTE_COUNT] = len_t'(declared_bytes_next) != half;
      flags[FLAG_CHECKSUM] = (byte_sum_next - last_byte_next) != ~last_byte_next;
    end
    flags[FLAG_COUNT] = beat.check_count &&
                        (len < len_t'(8) || count_field_next != beat.expected_count);

    result.error_flags = flags;
    result.first_error = first_set(flags);
    result.record_type = type_digit_next;
  end

  always_ff @(posedge clk) begin
    if (rst || (step && beat.line_end)) begin
      char_position <= '0;
      high_nibble <= '0;
      byte_sum <= '0;
      last_byte <= '0;
      declared_bytes <= '0;
      count_field <= '0;
      early_flags <= '0;
      type_digit <= '0;
    end else if (step) begin
      char_position <= char_position_next;
      high_nibble <= high_nibble_next;
      byte_sum <= byte_sum_next;
      last_byte <= last_byte_next;
      declared_bytes <= declared_bytes_next;
      count_field <= count_field_next;
      early_flags <= early_flags_next;
      type_digit <= type_digit_next;
    end
  end

endmodule

@@ test/tb.sv @@
// Self-checking testbench for the S-record line checker: character streams, predicted verdicts.
`timescale 1ns / 100ps

module tb;
  import srlc_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int SETTLE_CYCLES = 8;
  localparam logic [7:0] CH_LOWER_A = "a";

  typedef enum int {
    MANGLE_LEAD,
    MANGLE_TYPE,
    MANGLE_HEX,
    MANGLE_LOWER,
    MANGLE_COUNT,
    MANGLE_SUM,
    MANGLE_DROP,
    MANGLE_EXTRA,
    MANGLE_TRUNC
  } mangle_kind_e;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  char_code;
  logic        line_end;
  logic        check_count;
  logic [15:0] expected_count;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [5:0]  error_flags;
  logic [2:0]  first_error;
  logic [3:0]  record_type;

  pos_t        pos;
  logic [3:0]  hi_nib;
  logic [7:0]  byte_sum;
  logic [7:0]  last_byte;
  logic [7:0]  declared;
  logic [15:0] count_field;
  logic [2:0]  early_flags;
  logic [3:0]  type_digit;

  result_t line_verdicts[$];

  int send_gap_pct;
  int stall_pct;
  int n_chars;
  int n_lines;
  int n_count_checks;
  int n_results;
  int n_fail;
  int n_reported;
  int cycles;

  srecord_line_checker u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .line_end       (line_end),
    .check_count    (check_count),
    .expected_count (expected_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .error_flags    (error_flags),
    .first_error    (first_error),
    .record_type    (record_type)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= !rst && ($urandom_range(99) < stall_pct);
  end

  function automatic void clear_line_state();
    pos = '0;
    hi_nib = '0;
    byte_sum = '0;
    last_byte = '0;
    declared = '0;
    count_field = '0;
    early_flags = '0;
    type_digit = '0;
  endfunction

  // Folds one accepted character into the line state and, on the line end, queues the verdict.
  function automatic void advance_line(input logic [7:0] c, input logic last, input logic chk,
                                       input logic [15:0] want);
    logic       ok;
    logic [3:0] nib;
    logic [7:0] b;
    logic [7:0] rest;
    logic [5:0] flags;
    int         len;
    result_t    r;
    ok = 1'b1;
    nib = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      nib = c[3:0];
    end else if (c >= CH_A && c <= CH_F) begin
      nib = c[3:0] + 4'd9;
    end else begin
      ok = 1'b0;
    end
    if (pos == 0) begin
      if (c != CH_S) early_flags[FLAG_NO_S] = 1'b1;
    end else if (!ok) begin
      early_flags[FLAG_BAD_HEX] = 1'b1;
    end
    if (pos == 1) begin
      if (c >= CH_0 && c <= CH_9) begin
        type_digit = c[3:0];
      end else begin
        type_digit = 4'd0;
        early_flags[FLAG_BAD_TYPE] = 1'b1;
      end
    end
    if (pos >= 2) begin
      if (!pos[0]) begin
        hi_nib = nib;
      end else begin
        b = {hi_nib, nib};
        if (pos == 3) declared = b;
        byte_sum = byte_sum + b;
        last_byte = b;
      end
    end
    if (pos >= 4 && pos <= 7) count_field = {count_field[11:0], nib};
    if (!last) begin
      if (pos != LINE_CHARS - 1) pos = pos + 1'b1;
      return;
    end
    len = int'(pos) + 1;
    flags = {3'b000, early_flags};
    if (len < 2) flags[FLAG_BAD_TYPE] = 1'b1;
    if (len < 4 || (len % 2) != 0) begin
      flags[FLAG_BYTE_COUNT] = 1'b1;
      flags[FLAG_CHECKSUM] = 1'b1;
    end else begin
      rest = byte_sum - last_byte;
      if (int'(declared) != (len - 4) / 2) flags[FLAG_BYTE_COUNT] = 1'b1;
      if (rest != ~last_byte) flags[FLAG_CHECKSUM] = 1'b1;
    end
    if (chk) begin
      n_count_checks++;
      if (len < 8 || count_field != want) flags[FLAG_COUNT] = 1'b1;
    end
    r.error_flags = flags;
    r.first_error = 3'd0;
    for (int k = FLAG_W - 1; k >= 0; k--) begin
      if (flags[k]) r.first_error = 3'(k + 1);
    end
    r.record_type = type_digit;
    line_verdicts.push_back(r);
    n_lines++;
    clear_line_state();
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (!rst && out_valid && !out_stall) begin
      n_results++;
      if (line_verdicts.size() == 0) begin
        n_fail++;
        if (n_reported < MAX_REPORTS) begin
          n_reported++;
          $display("tb: unexpected result flags=%h first=%0d type=%0d",
                   error_flags, first_error, record_type);
        end
      end else begin
        want = line_verdicts.pop_front();
        if (error_flags !== want.error_flags || first_error !== want.first_error ||
            record_type !== want.record_type) begin
          n_fail++;
          if (n_reported < MAX_REPORTS) begin
            n_reported++;
            $display("tb: mismatch flags exp=%h got=%h first exp=%0d got=%0d type exp=%0d got=%0d",
                     want.error_flags, error_flags, want.first_error, first_error,
                     want.record_type, record_type);
          end
        end
      end
    end
  end

  function automatic logic [7:0] hex_digit(input logic [3:0] n);
    if (n < 10) return CH_0 + n;
    return CH_A + (n - 4'd10);
  endfunction

  // Builds a well-formed record: count byte, 16-bit address, data and checksum.
  function automatic void build_record(ref logic [7:0] line[$], input logic [3:0] typ,
                                       input logic [15:0] addr, input int n_data);
    logic [7:0] bytes[$];
    logic [7:0] sum;
    line.delete();
    bytes.push_back(8'(n_data + 3));
    bytes.push_back(addr[15:8]);
    bytes.push_back(addr[7:0]);
    repeat (n_data) bytes.push_back(8'($urandom));
    sum = '0;
    foreach (bytes[i]) sum += bytes[i];
    bytes.push_back(~sum);
    line.push_back(CH_S);
    line.push_back(CH_0 + typ);
    foreach (bytes[i]) begin
      line.push_back(hex_digit(bytes[i][7:4]));
      line.push_back(hex_digit(bytes[i][3:0]));
    end
  endfunction

  function automatic void mangle_record(ref logic [7:0] line[$], input mangle_kind_e kind);
    int at;
    at = $urandom_range(line.size() - 1, 1);
    case (kind)
      MANGLE_LEAD: line[0] = 8'($urandom);
      MANGLE_TYPE: line[1] = 8'($urandom);
      MANGLE_HEX: line[at] = 8'($urandom);
      MANGLE_LOWER: line[at] = CH_LOWER_A + 8'($urandom_range(5));
      MANGLE_COUNT: line[3] = hex_digit(4'($urandom));
      MANGLE_SUM: line[line.size() - 1] = hex_digit(4'($urandom));
      MANGLE_DROP: line.delete(at);
      MANGLE_EXTRA: line.insert(at, hex_digit(4'($urandom)));
      MANGLE_TRUNC: begin
        while (line.size() > at) void'(line.pop_back());
      end
      default: ;
    endcase
  endfunction

  // Presents one beat, called at a falling edge, and returns at the falling edge after acceptance.
  task automatic send_char(input logic [7:0] c, input logic last, input logic chk,
                           input logic [15:0] want);
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    char_code <= c;
    line_end <= last;
    check_count <= chk;
    expected_count <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    n_chars++;
    advance_line(c, last, chk, want);
    @(negedge clk);
  endtask

  task automatic send_line(input logic [7:0] line[$], input logic chk, input logic [15:0] want);
    foreach (line[i]) begin
      if (i == line.size() - 1) send_char(line[i], 1'b1, chk, want);
      else send_char(line[i], 1'b0, 1'($urandom), 16'($urandom));
    end
  endtask

  task automatic send_text(input string s, input logic chk, input logic [15:0] want);
    logic [7:0] line[$];
    foreach (s[i]) line.push_back(s[i]);
    send_line(line, chk, want);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (line_verdicts.size() != 0) @(negedge clk);
  endtask

  task automatic test_short_lines();
    send_text("S", 1'b1, 16'h0000);
    send_text("X", 1'b0, 16'h0000);
    send_text("S1", 1'b0, 16'h0000);
    send_text("S1F", 1'b1, 16'hFFFF);
    send_text("S0030000FC", 1'b1, 16'h0000);
    send_text("S10", 1'b0, 16'h0000);
  endtask

  task automatic test_character_set();
    logic [7:0] line[$];
    build_record(line, 4'd1, 16'h1234, 2);
    line[4] = 8'h3A;
    line[6] = 8'h40;
    send_line(line, 1'b0, 16'h0000);
    build_record(line, 4'd2, 16'hABCD, 1);
    line[8] = 8'h47;
    line[9] = CH_LOWER_A;
    send_line(line, 1'b0, 16'h0000);
    build_record(line, 4'd3, 16'h0F0F, 1);
    line[0] = 8'h00;
    line[1] = CH_A;
    line[5] = 8'hFF;
    send_line(line, 1'b0, 16'h0000);
    send_text("SS", 1'b0, 16'h0000);
  endtask

  task automatic test_well_formed();
    logic [7:0] line[$];
    build_record(line, 4'd0, 16'h0000, 0);
    send_line(line, 1'b1, 16'h0000);
    build_record(line, 4'd9, 16'hFFFF, 4);
    send_line(line, 1'b1, 16'hFFFF);
    build_record(line, 4'd5, 16'h5A5A, 3);
    send_line(line, 1'b1, 16'hA5A5);
    build_record(line, 4'd1, 16'h2000, 2);
    line[line.size() - 1] = (line[line.size() - 1] == CH_0) ? CH_F : CH_0;
    send_line(line, 1'b0, 16'h0000);
    build_record(line, 4'd1, 16'h2000, 2);
    line[3] = (line[3] == CH_9) ? CH_0 : CH_9;
    send_line(line, 1'b0, 16'h0000);
    build_record(line, 4'd8, 16'h3333, 1);
    void'(line.pop_back());
    send_line(line, 1'b1, 16'h3333);
  endtask

  // A line of exactly the store size, then one that runs past it.
  task automatic test_line_overflow();
    logic [7:0] line[$];
    line = {CH_S, CH_0 + 8'd1};
    while (line.size() < LINE_CHARS) line.push_back(hex_digit(4'($urandom)));
    send_line(line, 1'b1, 16'($urandom));
    line.delete();
    line = {CH_S, CH_0 + 8'd7};
    while (line.size() < LINE_CHARS + 6) line.push_back(hex_digit(4'($urandom)));
    send_line(line, 1'b0, 16'h0000);
  endtask

  task automatic send_random_line();
    logic [7:0]  line[$];
    logic [15:0] addr;
    logic [15:0] want;
    int          n_data;
    addr = 16'($urandom);
    if ($urandom_range(99) < 85) begin
      n_data = ($urandom_range(7) == 0) ? $urandom_range(40) : $urandom_range(8);
      build_record(line, 4'($urandom_range(9)), addr, n_data);
      if ($urandom_range(99) < 35) begin
        mangle_record(line, mangle_kind_e'($urandom_range(int'(MANGLE_TRUNC))));
      end
    end else begin
      repeat ($urandom_range(12, 1)) line.push_back(8'($urandom));
      if ($urandom_range(1)) line[0] = CH_S;
    end
    want = ($urandom_range(3) != 0) ? addr : 16'($urandom);
    send_line(line, 1'($urandom), want);
  endtask

  task automatic test_random_lines(input int min_chars, input int min_lines);
    int c0;
    int l0;
    c0 = n_chars;
    l0 = n_lines;
    while (n_chars - c0 < min_chars || n_lines - l0 < min_lines) send_random_line();
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    char_code = '0;
    line_end = 1'b0;
    check_count = 1'b0;
    expected_count = '0;
    send_gap_pct = 7;
    stall_pct = 66;
    clear_line_state();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_short_lines();
    test_character_set();
    test_well_formed();
    test_line_overflow();
    test_random_lines(250, 16);
    wait_drained();

    send_gap_pct = 66;
    stall_pct = 7;
    test_random_lines(250, 16);
    wait_drained();

    send_gap_pct = 0;
    stall_pct = 0;
    test_random_lines(250, 16);
    wait_drained();
    repeat (SETTLE_CYCLES) @(negedge clk);

    n_fail += line_verdicts.size();
    $display("tb: covered %0d lines of %0d characters, %0d with the count field compared,",
             n_lines, n_chars, n_count_checks);
    $display("tb: %0d verdicts checked under three idle patterns, %0d mismatched",
             n_results, n_fail);
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
